// ----- hdl/pnq_pkg.sv -----
// Shared constants, codes and types of the palette nearest colour quantizer.
// No dependencies; every other file in hdl imports this package.
package pnq_pkg;

    localparam int PALETTE_DEPTH = 255;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int LAB_W         = 16;
    localparam int WEIGHT_W      = 16;
    localparam int ALPHA_W       = 16;
    localparam int INDEX_W       = 8;
    localparam int PROD_W        = LAB_W + WEIGHT_W;
    localparam int SQ_W          = 2 * PROD_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_L   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_B   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_STEP = 2'd3;

    typedef struct packed {
        logic [LAB_W-1:0] l;
        logic [LAB_W-1:0] a;
        logic [LAB_W-1:0] b;
    } t_lab;

    // Sideband that travels with each palette entry through the distance pipe.
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [ADDR_W-1:0] idx;
    } t_tag;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] idx;
        t_lab              col;
    } t_best;

endpackage

// ----- hdl/pnq_palette_ram.sv -----
// Palette memory: one write port and one registered read port.
// Depends on pnq_pkg.
module pnq_palette_ram import pnq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_lab              i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_lab              o_rdata
);

    t_lab r_mem [PALETTE_DEPTH];
    t_lab r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pnq_dist_pipe.sv -----
// Weighted squared Lab distance pipeline and running minimum, one entry a beat.
// Depends on pnq_pkg.
module pnq_dist_pipe import pnq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tag                i_tag,
    input  t_lab                i_entry,
    input  t_lab                i_pix,
    input  logic [WEIGHT_W-1:0] i_weight_l,
    input  logic [WEIGHT_W-1:0] i_weight_a,
    input  logic [WEIGHT_W-1:0] i_weight_b,
    output t_best               o_best
);

    t_tag r_tag1, r_tag2, r_tag3, r_tag4;
    t_lab r_col1, r_col2, r_col3, r_col4;

    logic [LAB_W-1:0]  r_dl, r_da, r_db;
    logic [PROD_W-1:0] r_pl, r_pa, r_pb;
    logic [SQ_W-1:0]   r_sl, r_sa, r_sb;
    logic [DIST_W-1:0] r_sum;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_best_done;
    logic [ADDR_W-1:0] r_best_idx;
    t_lab              r_best_col;

    function automatic logic [LAB_W-1:0] abs_diff(input logic [LAB_W-1:0] x,
                                                  input logic [LAB_W-1:0] y);
        abs_diff = (x > y) ? (x - y) : (y - x);
    endfunction

    // Control: the tags carry the valid bits; they and the done flag are the only reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1      <= '0;
            r_tag2      <= '0;
            r_tag3      <= '0;
            r_tag4      <= '0;
            r_best_done <= 1'b0;
        end else begin
            r_tag1      <= i_tag;
            r_tag2      <= r_tag1;
            r_tag3      <= r_tag2;
            r_tag4      <= r_tag3;
            r_best_done <= r_tag4.vld & r_tag4.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl   <= abs_diff(i_entry.l, i_pix.l);
        r_da   <= abs_diff(i_entry.a, i_pix.a);
        r_db   <= abs_diff(i_entry.b, i_pix.b);
        r_col1 <= i_entry;

        r_pl   <= PROD_W'(r_dl) * PROD_W'(i_weight_l);
        r_pa   <= PROD_W'(r_da) * PROD_W'(i_weight_a);
        r_pb   <= PROD_W'(r_db) * PROD_W'(i_weight_b);
        r_col2 <= r_col1;

        r_sl   <= SQ_W'(r_pl) * SQ_W'(r_pl);
        r_sa   <= SQ_W'(r_pa) * SQ_W'(r_pa);
        r_sb   <= SQ_W'(r_pb) * SQ_W'(r_pb);
        r_col3 <= r_col2;

        r_sum  <= DIST_W'(r_sl) + DIST_W'(r_sa) + DIST_W'(r_sb);
        r_col4 <= r_col3;

        // Strict less-than keeps the lowest index on a tie.
        if (r_tag4.vld && (r_tag4.idx == '0 || r_sum < r_best_dist)) begin
            r_best_dist <= r_sum;
            r_best_idx  <= r_tag4.idx;
            r_best_col  <= r_col4;
        end
    end

    assign o_best = '{done: r_best_done, idx: r_best_idx, col: r_best_col};

endmodule

// ----- hdl/pnq_alpha_unit.sv -----
// Alpha rounding to a multiple of the step, with a bit-serial remainder.
// Depends on pnq_pkg.
module pnq_alpha_unit import pnq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [ALPHA_W-1:0] i_step,
    output logic               o_done,
    output logic [ALPHA_W-1:0] o_alpha
);

    localparam int BIT_CNT_W = $clog2(ALPHA_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state                r_state;
    logic                  r_done;
    logic [BIT_CNT_W-1:0]  r_bit;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [ALPHA_W-1:0]    r_step;
    logic [ALPHA_W-1:0]    r_dvd;
    logic [ALPHA_W-1:0]    r_rem;
    logic [ALPHA_W-1:0]    r_result;

    logic [ALPHA_W:0]      n_trial;
    logic [ALPHA_W-1:0]    n_rem;
    logic [ALPHA_W-1:0]    n_base;
    logic [ALPHA_W:0]      n_up;

    always_comb begin
        n_trial = {r_rem, r_dvd[ALPHA_W-1]};
        if (n_trial >= {1'b0, r_step}) begin
            n_rem = ALPHA_W'(n_trial - {1'b0, r_step});
        end else begin
            n_rem = n_trial[ALPHA_W-1:0];
        end
        n_base = r_alpha - r_rem;
        n_up   = {1'b0, n_base} + {1'b0, r_step};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_done  <= 1'b0;
                        r_alpha <= i_alpha;
                        r_step  <= i_step;
                        r_dvd   <= i_alpha;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[ALPHA_W-2:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BIT_CNT_W'(ALPHA_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // A zero step leaves the remainder at the dividend, so it is
                    // caught here and alpha passes through.
                    if (r_step == '0) begin
                        r_result <= r_alpha;
                    end else if (r_rem > (r_step >> 1)) begin
                        r_result <= n_up[ALPHA_W] ? '1 : n_up[ALPHA_W-1:0];
                    end else begin
                        r_result <= n_base;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_alpha = r_result;

endmodule

// ----- hdl/palette_nearest_color_quantizer.sv -----
// Palette nearest colour quantizer: top level with sequencer and registers.
// Loads and clears are taken while idle and do not raise busy. A pixel's result beat waits for
// the scan of one entry per cycle from the memory read port behind a five-stage distance pipe,
// and for the 16-step alpha remainder.
// A new pixel is taken only after the result beat of the previous one; busy drops with that beat.
// Reset (synchronous, active low) empties the palette and loads default weights.
module palette_nearest_color_quantizer import pnq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [LAB_W-1:0]      i_lab_l,
    input  logic [LAB_W-1:0]      i_lab_a,
    input  logic [LAB_W-1:0]      i_lab_b,
    input  logic [ALPHA_W-1:0]    i_alpha_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output logic [LAB_W-1:0]      o_out_l,
    output logic [LAB_W-1:0]      o_out_a,
    output logic [LAB_W-1:0]      o_out_b,
    output logic [ALPHA_W-1:0]    o_out_alpha,
    output logic [INDEX_W-1:0]    o_entry_index,
    output logic                  o_palette_empty
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state              r_state;
    logic                r_busy;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_rd_addr;
    t_tag                r_rd_tag;
    t_lab                r_pix;
    logic                r_srch_done;
    logic [WEIGHT_W-1:0] r_weight_l, r_weight_a, r_weight_b;
    logic [ALPHA_W-1:0]  r_alpha_step;

    logic                r_res_vld;
    t_lab                r_res_col;
    logic [ALPHA_W-1:0]  r_res_alpha;
    logic [INDEX_W-1:0]  r_res_idx;
    logic                r_res_empty;

    logic                n_accept;
    logic                n_pixel;
    logic                n_load;
    logic                n_rd_last;
    t_lab                n_in_lab;
    t_lab                n_entry;
    t_best               n_best;
    logic                n_alpha_done;
    logic [ALPHA_W-1:0]  n_alpha;

    assign n_accept  = start & ~r_busy;
    assign n_pixel   = n_accept & (i_func == FUNC_PIXEL);
    assign n_load    = n_accept & (i_func == FUNC_LOAD) & (r_count < CNT_W'(PALETTE_DEPTH));
    assign n_in_lab  = '{l: i_lab_l, a: i_lab_a, b: i_lab_b};
    assign n_rd_last = (r_rd_addr == ADDR_W'(r_count - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_l   <= WEIGHT_W'(256);
            r_weight_a   <= WEIGHT_W'(256);
            r_weight_b   <= WEIGHT_W'(256);
            r_alpha_step <= ALPHA_W'(32767);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WEIGHT_L:   r_weight_l   <= i_cfg_data;
                CFG_WEIGHT_A:   r_weight_a   <= i_cfg_data;
                CFG_WEIGHT_B:   r_weight_b   <= i_cfg_data;
                CFG_ALPHA_STEP: r_alpha_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pnq_palette_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (n_load),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (n_in_lab),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_rd_addr),
        .o_rdata (n_entry)
    );

    pnq_dist_pipe u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (r_rd_tag),
        .i_entry    (n_entry),
        .i_pix      (r_pix),
        .i_weight_l (r_weight_l),
        .i_weight_a (r_weight_a),
        .i_weight_b (r_weight_b),
        .o_best     (n_best)
    );

    pnq_alpha_unit u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_pixel),
        .i_alpha (i_alpha_in),
        .i_step  (r_alpha_step),
        .o_done  (n_alpha_done),
        .o_alpha (n_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= 1'b0;
            r_count      <= '0;
            r_rd_tag     <= '0;
            r_srch_done  <= 1'b0;
            r_res_vld    <= 1'b0;
        end else begin
            r_res_vld    <= 1'b0;
            r_rd_tag.vld <= 1'b0;
            if (n_best.done) begin
                r_srch_done <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_load) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (n_accept && i_func == FUNC_CLEAR) begin
                        r_count <= '0;
                    end
                    if (n_pixel) begin
                        r_busy      <= 1'b1;
                        r_pix       <= n_in_lab;
                        r_rd_addr   <= '0;
                        // An empty palette has nothing to search.
                        r_srch_done <= (r_count == '0);
                        r_state     <= (r_count == '0) ? S_WAIT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_tag.vld  <= 1'b1;
                    r_rd_tag.idx  <= r_rd_addr;
                    r_rd_tag.last <= n_rd_last;
                    r_rd_addr     <= r_rd_addr + 1'b1;
                    if (n_rd_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (r_srch_done && n_alpha_done) begin
                        r_res_vld   <= 1'b1;
                        r_res_alpha <= n_alpha;
                        r_res_empty <= (r_count == '0);
                        if (r_count == '0) begin
                            r_res_col <= '0;
                            r_res_idx <= '0;
                        end else begin
                            r_res_col <= n_best.col;
                            r_res_idx <= INDEX_W'(n_best.idx);
                        end
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = r_busy;
    assign o_result_valid  = r_res_vld;
    assign o_out_l         = r_res_col.l;
    assign o_out_a         = r_res_col.a;
    assign o_out_b         = r_res_col.b;
    assign o_out_alpha     = r_res_alpha;
    assign o_entry_index   = r_res_idx;
    assign o_palette_empty = r_res_empty;

    // A result beat closes a pixel that was in progress.
    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && $past(busy)))
        else $error("result beat without a pixel in progress");

    // The scan only reads entries that have been loaded.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_rd_addr) < r_count))
        else $error("palette read beyond the stored entries");

    // An empty palette gives a zero colour and index.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_palette_empty) |->
            (o_entry_index == '0 && o_out_l == '0 && o_out_a == '0 && o_out_b == '0))
        else $error("empty palette result carries a colour");

    // The palette is never written while a pixel search is running.
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_count))
        else $error("entry count changed during a search");

endmodule

// ----- tb/sv/palette_nearest_color_quantizer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the palette nearest colour quantizer: drives command beats,
// keeps its own shadow palette and registers, and checks every pixel result in order.
// Depends on pnq_pkg and palette_nearest_color_quantizer.
module palette_nearest_color_quantizer_tb;
    import pnq_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        t_lab               col;
        logic [ALPHA_W-1:0] alpha;
        logic [INDEX_W-1:0] idx;
        logic               empty;
        int                 seq;
    } t_quant_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_func;
    logic [LAB_W-1:0]      i_lab_l;
    logic [LAB_W-1:0]      i_lab_a;
    logic [LAB_W-1:0]      i_lab_b;
    logic [ALPHA_W-1:0]    i_alpha_in;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_result_valid;
    logic [LAB_W-1:0]      o_out_l;
    logic [LAB_W-1:0]      o_out_a;
    logic [LAB_W-1:0]      o_out_b;
    logic [ALPHA_W-1:0]    o_out_alpha;
    logic [INDEX_W-1:0]    o_entry_index;
    logic                  o_palette_empty;

    // Shadow copy of the palette and the registers.
    t_lab                  pal_shadow [PALETTE_DEPTH];
    int                    pal_fill;
    logic [WEIGHT_W-1:0]   weight_l_shadow;
    logic [WEIGHT_W-1:0]   weight_a_shadow;
    logic [WEIGHT_W-1:0]   weight_b_shadow;
    logic [ALPHA_W-1:0]    alpha_step_shadow;

    t_quant_result         pending_colours [$];
    int                    pixels_sent;
    int                    items_counted;
    int                    n_errors;
    bit                    gaps_enabled;

    palette_nearest_color_quantizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_lab_l         (i_lab_l),
        .i_lab_a         (i_lab_a),
        .i_lab_b         (i_lab_b),
        .i_alpha_in      (i_alpha_in),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_out_l         (o_out_l),
        .o_out_a         (o_out_a),
        .o_out_b         (o_out_b),
        .o_out_alpha     (o_out_alpha),
        .o_entry_index   (o_entry_index),
        .o_palette_empty (o_palette_empty)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic logic [DIST_W-1:0] axis_term(input logic [LAB_W-1:0] x,
                                                    input logic [LAB_W-1:0] y,
                                                    input logic [WEIGHT_W-1:0] w);
        logic [LAB_W-1:0]  diff;
        logic [PROD_W-1:0] prod;
        diff = (x > y) ? x - y : y - x;
        prod = PROD_W'(diff) * PROD_W'(w);
        return DIST_W'(prod) * DIST_W'(prod);
    endfunction

    // Exhaustive search of the shadow palette; strict less-than keeps the lowest index on a tie.
    function automatic t_quant_result nearest_colour(input t_lab px,
                                                     input logic [ALPHA_W-1:0] alpha);
        t_quant_result     r;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] best_d;
        logic [ALPHA_W-1:0] rem;
        logic [ALPHA_W:0]   up;
        r.col   = '0;
        r.idx   = '0;
        r.empty = 1'b1;
        r.seq   = 0;
        r.alpha = alpha;
        if (alpha_step_shadow != 0) begin
            rem = alpha % alpha_step_shadow;
            if (rem > (alpha_step_shadow >> 1)) begin
                up      = {1'b0, alpha - rem} + alpha_step_shadow;
                r.alpha = (up > 17'h0FFFF) ? 16'hFFFF : up[ALPHA_W-1:0];
            end else begin
                r.alpha = alpha - rem;
            end
        end
        best_d = '0;
        for (int k = 0; k < pal_fill; k++) begin
            d = axis_term(pal_shadow[k].l, px.l, weight_l_shadow)
              + axis_term(pal_shadow[k].a, px.a, weight_a_shadow)
              + axis_term(pal_shadow[k].b, px.b, weight_b_shadow);
            if (k == 0 || d < best_d) begin
                best_d  = d;
                r.col   = pal_shadow[k];
                r.idx   = INDEX_W'(k);
                r.empty = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] edge_biased();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_lab random_colour();
        t_lab c;
        c.l = edge_biased();
        c.a = edge_biased();
        c.b = edge_biased();
        return c;
    endfunction

    // Now and then lands exactly on, or one past, the half-step rounding boundary.
    function automatic logic [ALPHA_W-1:0] random_alpha();
        int unsigned v;
        if (alpha_step_shadow != 0 && $urandom_range(3) == 0) begin
            v = $urandom_range(65535 / alpha_step_shadow) * alpha_step_shadow
              + alpha_step_shadow / 2 + $urandom_range(1);
            if (v > 65535) v = 65535;
            return ALPHA_W'(v);
        end
        return edge_biased();
    endfunction

    function automatic logic [WEIGHT_W-1:0] random_weight();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] random_step();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(2, 300));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Sends one command beat and updates the shadow state once the beat is taken.
    task automatic issue_command(input logic [1:0] func, input t_lab c,
                                 input logic [ALPHA_W-1:0] alpha);
        t_quant_result want;
        while (gaps_enabled && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_func     <= func;
        i_lab_l    <= c.l;
        i_lab_a    <= c.a;
        i_lab_b    <= c.b;
        i_alpha_in <= alpha;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (func)
            FUNC_LOAD: begin
                if (pal_fill < PALETTE_DEPTH) begin
                    pal_shadow[pal_fill] = c;
                    pal_fill++;
                    items_counted++;
                end
            end
            FUNC_PIXEL: begin
                want     = nearest_colour(c, alpha);
                want.seq = pixels_sent++;
                pending_colours.push_back(want);
                items_counted++;
            end
            FUNC_CLEAR: begin
                pal_fill = 0;
                items_counted++;
            end
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_colours.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        // Loads and clears give no result, so allow the block to settle after the last one.
        repeat (24) @(posedge i_clk);
        if (pending_colours.size() != 0) begin
            report_mismatch($sformatf("%0d pixel results never arrived",
                                      pending_colours.size()));
            pending_colours.delete();
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_WEIGHT_L:   weight_l_shadow   = val;
            CFG_WEIGHT_A:   weight_a_shadow   = val;
            CFG_WEIGHT_B:   weight_b_shadow   = val;
            CFG_ALPHA_STEP: alpha_step_shadow = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [15:0] wl, input logic [15:0] wa,
                                input logic [15:0] wb, input logic [15:0] step);
        put_reg(CFG_WEIGHT_L, wl);
        put_reg(CFG_WEIGHT_A, wa);
        put_reg(CFG_WEIGHT_B, wb);
        put_reg(CFG_ALPHA_STEP, step);
        i_cfg_we <= 1'b0;
    endtask

    task automatic small_scene();
        issue_command(FUNC_CLEAR, random_colour(), random_alpha());
        issue_command(FUNC_LOAD, '{16'h0000, 16'h0000, 16'h0000}, 16'h0000);
        issue_command(FUNC_LOAD, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'hFFFF);
        repeat (2) issue_command(FUNC_LOAD, random_colour(), random_alpha());
        issue_command(FUNC_PIXEL, '{16'hFFFF, 16'h0000, 16'hFFFF}, 16'h0000);
        issue_command(FUNC_PIXEL, '{16'h0000, 16'hFFFF, 16'h0000}, 16'hFFFF);
        repeat (4) issue_command(FUNC_PIXEL, random_colour(), random_alpha());
    endtask

    task automatic test_directed_corners();
        gaps_enabled = 1'b1;
        // Empty palette straight after reset, alpha around the default half step.
        issue_command(FUNC_PIXEL, '{16'h0000, 16'h0000, 16'h0000}, 16'h0000);
        issue_command(FUNC_PIXEL, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'hFFFF);
        issue_command(FUNC_PIXEL, '{16'h1234, 16'h8000, 16'h8000}, 16'd16383);
        issue_command(FUNC_PIXEL, '{16'h4321, 16'h8000, 16'h8000}, 16'd16384);
        issue_command(FUNC_UNUSED, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'hFFFF);
        issue_command(FUNC_LOAD, '{16'h0000, 16'h0000, 16'h0000}, 16'hFFFF);
        issue_command(FUNC_LOAD, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'h0000);
        issue_command(FUNC_LOAD, '{16'h1000, 16'h8000, 16'h8000}, 16'h0000);
        issue_command(FUNC_LOAD, '{16'h3000, 16'h8000, 16'h8000}, 16'h0000);
        issue_command(FUNC_LOAD, '{16'h1000, 16'h8000, 16'h8000}, 16'h0000);
        issue_command(FUNC_PIXEL, '{16'h0000, 16'h0000, 16'h0000}, 16'h5555);
        issue_command(FUNC_PIXEL, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'hAAAA);
        // Halfway between two entries, and an exact match of a duplicated entry.
        issue_command(FUNC_PIXEL, '{16'h2000, 16'h8000, 16'h8000}, 16'd32767);
        issue_command(FUNC_PIXEL, '{16'h1000, 16'h8000, 16'h8000}, 16'd32768);
        issue_command(FUNC_PIXEL, '{16'h8000, 16'h0000, 16'hFFFF}, 16'd49151);
        issue_command(FUNC_CLEAR, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 16'hFFFF);
        issue_command(FUNC_PIXEL, '{16'h1000, 16'h8000, 16'h8000}, 16'd49152);
    endtask

    task automatic test_weight_extremes();
        wait_idle();
        write_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        small_scene();
        wait_idle();
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
        small_scene();
        wait_idle();
        write_config(16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF);
        small_scene();
        issue_command(FUNC_PIXEL, random_colour(), 16'd40000);
        wait_idle();
        write_config(16'd256, 16'd256, 16'd256, 16'd40000);
        small_scene();
        // Rounding up past the top saturates; exactly half a step rounds down.
        issue_command(FUNC_PIXEL, random_colour(), 16'd65000);
        issue_command(FUNC_PIXEL, random_colour(), 16'd60000);
        issue_command(FUNC_PIXEL, random_colour(), 16'd60001);
        wait_idle();
        write_config(16'h0001, 16'h0080, 16'h0200, 16'h0002);
        small_scene();
    endtask

    task automatic test_full_palette();
        issue_command(FUNC_CLEAR, random_colour(), random_alpha());
        repeat (PALETTE_DEPTH - 1) issue_command(FUNC_LOAD, random_colour(), random_alpha());
        issue_command(FUNC_LOAD, '{16'h1234, 16'h5678, 16'h9ABC}, 16'h0000);
        // The palette is full, so these loads must leave it unchanged.
        repeat (3) issue_command(FUNC_LOAD, '{16'h1234, 16'h5678, 16'h9ABC}, 16'h0000);
        issue_command(FUNC_PIXEL, '{16'h1234, 16'h5678, 16'h9ABC}, random_alpha());
        issue_command(FUNC_PIXEL, '{16'h0000, 16'h0000, 16'h0000}, random_alpha());
        issue_command(FUNC_PIXEL, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, random_alpha());
        repeat (4) issue_command(FUNC_PIXEL, random_colour(), random_alpha());
    endtask

    // One sequence: an occasional clear, a few loads (rarely many), then pixels and noise.
    task automatic run_frame();
        int   n_load;
        t_lab c;
        if ($urandom_range(3) == 0) issue_command(FUNC_CLEAR, random_colour(), random_alpha());
        n_load = ($urandom_range(19) == 0) ? $urandom_range(PALETTE_DEPTH) : $urandom_range(6);
        repeat (n_load) begin
            if (pal_fill > 0 && $urandom_range(9) == 0) c = pal_shadow[$urandom_range(pal_fill - 1)];
            else c = random_colour();
            issue_command(FUNC_LOAD, c, random_alpha());
        end
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(9))
                0: issue_command(FUNC_UNUSED, random_colour(), random_alpha());
                1, 2, 3, 4: begin
                    if (pal_fill > 0) begin
                        c = pal_shadow[$urandom_range(pal_fill - 1)];
                        c.l = c.l + 16'($urandom_range(8)) - 16'd4;
                        c.a = c.a + 16'($urandom_range(8)) - 16'd4;
                        c.b = c.b + 16'($urandom_range(8)) - 16'd4;
                    end else begin
                        c = random_colour();
                    end
                    issue_command(FUNC_PIXEL, c, random_alpha());
                end
                default: issue_command(FUNC_PIXEL, random_colour(), random_alpha());
            endcase
        end
    endtask

    task automatic test_random_traffic();
        int target;
        int phase_base;
        int phase;
        target = items_counted + 400;
        phase  = 0;
        while (items_counted < target) begin
            if (phase > 0) begin
                wait_idle();
                write_config(random_weight(), random_weight(), random_weight(), random_step());
            end
            // The first phase runs back to back; later ones have random gaps.
            gaps_enabled = (phase != 0);
            phase_base   = items_counted;
            while (items_counted - phase_base < 100) run_frame();
            phase++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_quant_result want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_colours.size() == 0) begin
                report_mismatch("result beat with no pixel outstanding");
            end else begin
                want = pending_colours.pop_front();
                if (o_out_l !== want.col.l)
                    report_mismatch($sformatf("pixel %0d out_l %h want %h",
                                              want.seq, o_out_l, want.col.l));
                if (o_out_a !== want.col.a)
                    report_mismatch($sformatf("pixel %0d out_a %h want %h",
                                              want.seq, o_out_a, want.col.a));
                if (o_out_b !== want.col.b)
                    report_mismatch($sformatf("pixel %0d out_b %h want %h",
                                              want.seq, o_out_b, want.col.b));
                if (o_out_alpha !== want.alpha)
                    report_mismatch($sformatf("pixel %0d out_alpha %h want %h",
                                              want.seq, o_out_alpha, want.alpha));
                if (o_entry_index !== want.idx)
                    report_mismatch($sformatf("pixel %0d entry_index %0d want %0d",
                                              want.seq, o_entry_index, want.idx));
                if (o_palette_empty !== want.empty)
                    report_mismatch($sformatf("pixel %0d palette_empty %b want %b",
                                              want.seq, o_palette_empty, want.empty));
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_func     <= FUNC_LOAD;
        i_lab_l    <= '0;
        i_lab_a    <= '0;
        i_lab_b    <= '0;
        i_alpha_in <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_WEIGHT_L;
        i_cfg_data <= '0;
        pal_fill          = 0;
        weight_l_shadow   = 16'd256;
        weight_a_shadow   = 16'd256;
        weight_b_shadow   = 16'd256;
        alpha_step_shadow = 16'd32767;
        pixels_sent       = 0;
        items_counted     = 0;
        n_errors          = 0;
        gaps_enabled      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_weight_extremes();
        test_full_palette();
        test_random_traffic();

        wait_idle();
        if (n_errors == 0) begin
            $display("palette_nearest_color_quantizer_tb: PASS");
        end else begin
            $display("palette_nearest_color_quantizer_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("palette_nearest_color_quantizer_tb: FAIL");
        $finish;
    end

endmodule
